@@ rtl/bhpq_pkg.sv @@
`timescale 1ns / 1ps

package bhpq_pkg;

	// default sizes
	localparam int DEF_DEPTH     = 1024;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int DEF_TAG_WIDTH = 16;
	localparam int DEF_CNT_WIDTH = $clog2(DEF_DEPTH + 1);

	// request commands
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// response status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// read address sources
	localparam logic [2:0] RD_PARENT = 3'd0;
	localparam logic [2:0] RD_ROOT   = 3'd1;
	localparam logic [2:0] RD_LAST   = 3'd2;
	localparam logic [2:0] RD_KID    = 3'd3;
	localparam logic [2:0] RD_KID1   = 3'd4;
	localparam logic [2:0] RD_SCAN   = 3'd5;

	// write data sources
	localparam logic [1:0] WR_ITEM  = 2'd0;
	localparam logic [1:0] WR_RDATA = 2'd1;
	localparam logic [1:0] WR_SEL   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cnt_clr;
		logic       pos_tail;
		logic       pos_root;
		logic       pos_parent;
		logic       pos_sel;
		logic       scan_init;
		logic       scan_step;
		logic       rd_en;
		logic [2:0] rd_src;
		logic       wr_en;
		logic [1:0] wr_src;
		logic       left_cap;
		logic       root_cap;
		logic       item_from_rd;
		logic       pair;
		logic       res_set;
		logic [1:0] res_code;
		logic       out_load;
	} bhpq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       multi;
		logic       at_root;
		logic       parent_loses;
		logic       kid_out;
		logic       has_right;
		logic       item_wins;
		logic       tag_hit;
		logic       scan_done;
		logic       moved;
	} bhpq_stat_t;

endpackage

@@ rtl/bhpq_in_if.sv @@
`timescale 1ns / 1ps

interface bhpq_in_if
	import bhpq_pkg::*;
#(
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = DEF_TAG_WIDTH
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic [KEY_WIDTH-1:0] key;
	logic [TAG_WIDTH-1:0] tag;

	modport source (output valid, command, key, tag, input ready);
	modport sink (input valid, command, key, tag, output ready);
endinterface

@@ rtl/bhpq_out_if.sv @@
`timescale 1ns / 1ps

interface bhpq_out_if
	import bhpq_pkg::*;
#(
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = DEF_TAG_WIDTH,
	parameter int CNT_WIDTH = DEF_CNT_WIDTH
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [KEY_WIDTH-1:0] out_key;
	logic [TAG_WIDTH-1:0] out_tag;
	logic [CNT_WIDTH-1:0] count;

	modport source (output valid, status, out_key, out_tag, count, input ready);
	modport sink (input valid, status, out_key, out_tag, count, output ready);
endinterface

@@ rtl/bhpq_cfg_if.sv @@
`timescale 1ns / 1ps

interface bhpq_cfg_if;
	logic valid;
	logic ready;
	logic order_mode;

	modport source (output valid, order_mode, input ready);
	modport sink (input valid, order_mode, output ready);
endinterface

@@ rtl/binary_heap_priority_queue.sv @@
`timescale 1ns / 1ps

// binary heap priority queue: up to DEPTH key/tag entries in a one-based heap held
// in a single simple dual-port ram, min-heap or max-heap per order_mode. one request
// beat gives exactly one response beat. a request is taken whenever the sequencer is
// idle, even while the previous response still waits on rsp.ready. the heap ram has
// one registered read port, so cost is set by ram reads walking the tree: insert and
// pop grow with L, the number of levels moved (at most log2(DEPTH), 10 at the default
// depth); update scans tags from the root up to the first matching entry, then does
// one sift; clear and the error cases do no tree walk. no clearing pass is needed
// after reset. order_mode may only be written while no request is in flight.

module binary_heap_priority_queue
	import bhpq_pkg::*;
#(
	parameter int DEPTH     = DEF_DEPTH,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = DEF_TAG_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	bhpq_cfg_if.sink    cfg,
	bhpq_in_if.sink     req,
	bhpq_out_if.source  rsp
);
	// entry count must hold DEPTH itself
	localparam int CNT_WIDTH = $clog2(DEPTH + 1);

	bhpq_cmd_t  cmd;
	bhpq_stat_t stat;

	// config register is always writable
	assign cfg.ready = 1'b1;

	// sequencer: walks insert, pop, update and clear step by step
	bhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// heap ram, item and position registers, response register
	bhpq_dpath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH),
		.TAG_WIDTH (TAG_WIDTH),
		.CNT_WIDTH (CNT_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_mode   (cfg.order_mode),
		.in_command (req.command),
		.in_key     (req.key),
		.in_tag     (req.tag),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (rsp.status),
		.out_key    (rsp.out_key),
		.out_tag    (rsp.out_tag),
		.out_count  (rsp.count)
	);
endmodule

@@ rtl/bhpq_ram.sv @@
`timescale 1ns / 1ps

module bhpq_ram
	import bhpq_pkg::*;
#(
	parameter int WIDTH = DEF_KEY_WIDTH + DEF_TAG_WIDTH,
	parameter int DEPTH = DEF_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/bhpq_ctrl.sv @@
`timescale 1ns / 1ps

module bhpq_ctrl
	import bhpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output bhpq_cmd_t  cmd,
	input  bhpq_stat_t stat
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_UP     = 4'd2;
	localparam logic [3:0] S_UP_CMP = 4'd3;
	localparam logic [3:0] S_POP1   = 4'd4;
	localparam logic [3:0] S_POP2   = 4'd5;
	localparam logic [3:0] S_DN     = 4'd6;
	localparam logic [3:0] S_DN_L   = 4'd7;
	localparam logic [3:0] S_DN_R   = 4'd8;
	localparam logic [3:0] S_SCAN   = 4'd9;
	localparam logic [3:0] S_RESULT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_FULL;
							state_nxt    = S_RESULT;
						end else begin
							cmd.cnt_inc  = 1'b1;
							cmd.pos_tail = 1'b1;
							state_nxt    = S_UP;
						end
					end
					OP_POP: begin
						if (stat.empty) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_EMPTY;
							state_nxt    = S_RESULT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RD_ROOT;
							state_nxt  = S_POP1;
						end
					end
					OP_UPDATE: begin
						if (stat.empty) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_EMPTY;
							state_nxt    = S_RESULT;
						end else begin
							cmd.scan_init = 1'b1;
							state_nxt     = S_SCAN;
						end
					end
					default: begin
						cmd.cnt_clr  = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_OK;
						state_nxt    = S_RESULT;
					end
				endcase
			end
			S_UP, S_UP_CMP: begin
				if (state_q == S_UP && !stat.at_root) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_PARENT;
					state_nxt  = S_UP_CMP;
				end else if (state_q == S_UP_CMP && stat.parent_loses) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_src     = WR_RDATA;
					cmd.pos_parent = 1'b1;
					state_nxt      = S_UP;
				end else if (stat.op == OP_UPDATE && !stat.moved) begin
					// updated entry stayed put, try the other direction
					state_nxt = S_DN;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_src   = WR_ITEM;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_nxt    = S_RESULT;
				end
			end
			S_POP1: begin
				cmd.root_cap = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_src   = RD_LAST;
				state_nxt    = S_POP2;
			end
			S_POP2: begin
				cmd.item_from_rd = 1'b1;
				cmd.cnt_dec      = 1'b1;
				if (stat.multi) begin
					cmd.pos_root = 1'b1;
					state_nxt    = S_DN;
				end else begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_nxt    = S_RESULT;
				end
			end
			S_DN: begin
				if (stat.kid_out) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_src   = WR_ITEM;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_nxt    = S_RESULT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_KID;
					state_nxt  = S_DN_L;
				end
			end
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L && stat.has_right) begin
					cmd.left_cap = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_src   = RD_KID1;
					state_nxt    = S_DN_R;
				end else begin
					cmd.pair = (state_q == S_DN_R);
					if (stat.item_wins) begin
						cmd.wr_en    = 1'b1;
						cmd.wr_src   = WR_ITEM;
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_OK;
						state_nxt    = S_RESULT;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_src  = WR_SEL;
						cmd.pos_sel = 1'b1;
						state_nxt   = S_DN;
					end
				end
			end
			S_SCAN: begin
				if (stat.tag_hit) begin
					state_nxt = S_UP;
				end else if (stat.scan_done) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NOTFOUND;
					state_nxt    = S_RESULT;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_src    = RD_SCAN;
					cmd.scan_step = 1'b1;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

@@ rtl/bhpq_dpath.sv @@
`timescale 1ns / 1ps

module bhpq_dpath
	import bhpq_pkg::*;
#(
	parameter int DEPTH     = DEF_DEPTH,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = DEF_TAG_WIDTH,
	parameter int CNT_WIDTH = DEF_CNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_mode,
	input  logic [1:0]           in_command,
	input  logic [KEY_WIDTH-1:0] in_key,
	input  logic [TAG_WIDTH-1:0] in_tag,
	input  bhpq_cmd_t            cmd,
	output bhpq_stat_t           stat,
	output logic [1:0]           out_status,
	output logic [KEY_WIDTH-1:0] out_key,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic [CNT_WIDTH-1:0] out_count
);
	localparam int AW = $clog2(DEPTH);
	localparam int EW = KEY_WIDTH + TAG_WIDTH;
	localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);
	localparam logic [CNT_WIDTH-1:0] ONE_CNT  = CNT_WIDTH'(1);

	function automatic logic beats(input logic mode, input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b);
		beats = mode ? (a > b) : (a < b);
	endfunction

	logic                 order_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic                 moved_q;
	logic                 chk_q;
	logic [1:0]           op_q;
	logic [KEY_WIDTH-1:0] item_key_q;
	logic [TAG_WIDTH-1:0] item_tag_q;
	logic [KEY_WIDTH-1:0] left_key_q;
	logic [TAG_WIDTH-1:0] left_tag_q;
	logic [KEY_WIDTH-1:0] root_key_q;
	logic [TAG_WIDTH-1:0] root_tag_q;
	logic [CNT_WIDTH-1:0] pos_q;
	logic [CNT_WIDTH:0]   scan_q;
	logic [1:0]           res_q;
	logic [1:0]           out_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [TAG_WIDTH-1:0] out_tag_q;
	logic [CNT_WIDTH-1:0] out_count_q;

	logic [EW-1:0]        rdata;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [TAG_WIDTH-1:0] rd_tag;
	logic [EW-1:0]        wdata;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;

	logic [CNT_WIDTH:0]   cnt_x;
	logic [CNT_WIDTH:0]   cnt_p1;
	logic [CNT_WIDTH:0]   kid;
	logic [CNT_WIDTH:0]   kid1;
	logic [CNT_WIDTH:0]   kid_m1;
	logic [CNT_WIDTH:0]   scan_m1;
	logic [CNT_WIDTH:0]   sel_pos;
	logic [CNT_WIDTH-1:0] pos_m1;
	logic [CNT_WIDTH-1:0] par;
	logic [CNT_WIDTH-1:0] par_m1;
	logic [CNT_WIDTH-1:0] last_m1;
	logic                 right_pick;
	logic [KEY_WIDTH-1:0] sel_key;
	logic [TAG_WIDTH-1:0] sel_tag;

	assign rd_key = rdata[EW-1:TAG_WIDTH];
	assign rd_tag = rdata[TAG_WIDTH-1:0];

	// position arithmetic, one-based heap indices
	assign cnt_x   = {1'b0, count_q};
	assign cnt_p1  = cnt_x + 1'b1;
	assign kid     = {pos_q, 1'b0};
	assign kid1    = {pos_q, 1'b1};
	assign kid_m1  = kid - 1'b1;
	assign scan_m1 = scan_q - 1'b1;
	assign pos_m1  = pos_q - 1'b1;
	assign par     = pos_q >> 1;
	assign par_m1  = par - 1'b1;
	assign last_m1 = count_q - 1'b1;

	// child choice: right wins unless left strictly beats it
	assign right_pick = !beats(order_q, left_key_q, rd_key);
	assign sel_key    = (cmd.pair && !right_pick) ? left_key_q : rd_key;
	assign sel_tag    = (cmd.pair && !right_pick) ? left_tag_q : rd_tag;
	assign sel_pos    = (cmd.pair && right_pick) ? kid1 : kid;

	always_comb begin
		case (cmd.rd_src)
			RD_PARENT: raddr = par_m1[AW-1:0];
			RD_ROOT:   raddr = '0;
			RD_LAST:   raddr = last_m1[AW-1:0];
			RD_KID:    raddr = kid_m1[AW-1:0];
			RD_KID1:   raddr = kid[AW-1:0];
			RD_SCAN:   raddr = scan_m1[AW-1:0];
			default:   raddr = '0;
		endcase
	end

	always_comb begin
		case (cmd.wr_src)
			WR_ITEM:  wdata = {item_key_q, item_tag_q};
			WR_RDATA: wdata = rdata;
			WR_SEL:   wdata = {sel_key, sel_tag};
			default:  wdata = {item_key_q, item_tag_q};
		endcase
	end

	assign waddr = pos_m1[AW-1:0];

	bhpq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		stat              = '0;
		stat.op           = op_q;
		stat.full         = (count_q == FULL_CNT);
		stat.empty        = (count_q == '0);
		stat.multi        = (count_q > ONE_CNT);
		stat.at_root      = (pos_q == ONE_CNT);
		stat.parent_loses = beats(order_q, item_key_q, rd_key);
		stat.kid_out      = (kid > cnt_x);
		stat.has_right    = (kid < cnt_x);
		stat.item_wins    = beats(order_q, item_key_q, sel_key);
		stat.tag_hit      = chk_q && (rd_tag == item_tag_q);
		stat.scan_done    = (scan_q > cnt_x);
		stat.moved        = moved_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			count_q <= '0;
			moved_q <= 1'b0;
			chk_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_mode;
			end
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= cnt_p1[CNT_WIDTH-1:0];
			end else if (cmd.cnt_dec) begin
				count_q <= last_m1;
			end
			if (cmd.load) begin
				moved_q <= 1'b0;
			end else if (cmd.pos_parent) begin
				moved_q <= 1'b1;
			end
			chk_q <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_command;
			item_key_q <= in_key;
			item_tag_q <= in_tag;
			root_key_q <= '0;
			root_tag_q <= '0;
		end
		if (cmd.item_from_rd) begin
			item_key_q <= rd_key;
			item_tag_q <= rd_tag;
		end
		if (cmd.root_cap) begin
			root_key_q <= rd_key;
			root_tag_q <= rd_tag;
		end
		if (cmd.left_cap) begin
			left_key_q <= rd_key;
			left_tag_q <= rd_tag;
		end
		if (cmd.pos_tail) begin
			pos_q <= cnt_p1[CNT_WIDTH-1:0];
		end else if (cmd.pos_root) begin
			pos_q <= ONE_CNT;
		end else if (cmd.pos_parent) begin
			pos_q <= par;
		end else if (cmd.pos_sel) begin
			pos_q <= sel_pos[CNT_WIDTH-1:0];
		end else if (cmd.scan_step) begin
			pos_q <= scan_q[CNT_WIDTH-1:0];
		end
		if (cmd.scan_init) begin
			scan_q <= {{CNT_WIDTH{1'b0}}, 1'b1};
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_code;
		end
		if (cmd.out_load) begin
			out_status_q <= res_q;
			out_key_q    <= root_key_q;
			out_tag_q    <= root_tag_q;
			out_count_q  <= count_q;
		end
	end

	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_tag    = out_tag_q;
	assign out_count  = out_count_q;
endmodule

@@ rtl/bhpq_chk.sv @@
`timescale 1ns / 1ps

module bhpq_chk
	import bhpq_pkg::*;
#(
	parameter int DEPTH     = DEF_DEPTH,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = DEF_TAG_WIDTH,
	parameter int CNT_WIDTH = DEF_CNT_WIDTH
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [1:0]           rsp_status,
	input logic [KEY_WIDTH-1:0] rsp_key,
	input logic [TAG_WIDTH-1:0] rsp_tag,
	input logic [CNT_WIDTH-1:0] rsp_count
);
	localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

	// a response beat is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_key)
			&& $stable(rsp_tag) && $stable(rsp_count))
		else $error("response payload changed while stalled");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= FULL_CNT)
		else $error("entry count beyond depth");

	// only a successful pop carries an entry
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_key == '0 && rsp_tag == '0)
		else $error("error response carries an entry");

	a_err_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL) |->
			(rsp_status == ST_EMPTY && rsp_count == '0)
			|| (rsp_status == ST_FULL && rsp_count == FULL_CNT))
		else $error("empty or full status disagrees with count");
endmodule

bind binary_heap_priority_queue bhpq_chk #(
	.DEPTH     (DEPTH),
	.KEY_WIDTH (KEY_WIDTH),
	.TAG_WIDTH (TAG_WIDTH),
	.CNT_WIDTH (CNT_WIDTH)
) u_bhpq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_key    (rsp.out_key),
	.rsp_tag    (rsp.out_tag),
	.rsp_count  (rsp.count)
);
